// ===== design/ckct_pkg.sv =====
`timescale 1ns / 1ps
package ckct_pkg;

  localparam int KMER_W = 62;
  localparam int OCC_W  = 32;
  localparam logic [31:0] SCATTER_A = 32'h961C69E3;
  localparam logic [31:0] SCATTER_B = 32'h69E3961C;

  typedef enum logic [1:0] {
    OP_COUNT  = 2'd0,
    OP_BUILD  = 2'd1,
    OP_INSERT = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NOT_FOUND   = 2'd1,
    ST_OVERFLOW    = 2'd2,
    ST_WRONG_PHASE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_CNT_WR, S_BLD_RD, S_BLD_WR,
    S_INS_RD1, S_INS_CHK, S_QRY_RD, S_QRY_LAT, S_SCAN_RD, S_SCAN_CMP
  } state_t;

  typedef enum logic [1:0] {
    RA_ITEM, RA_NEXT, RA_CANON, RA_WALK
  } raddr_sel_t;

  typedef enum logic [1:0] {
    WS_ZERO, WS_INC, WS_SUM
  } wsel_t;

  typedef struct packed {
    logic       in_ready;
    logic       in_load;
    logic       canon_load;
    logic       start_rd;
    logic       fill_rd;
    raddr_sel_t raddr_sel;
    logic       start_we;
    wsel_t      start_wsel;
    logic       fill_we;
    logic       fill_zero;
    logic       total_inc;
    logic       phase_set;
    logic       walk_clr;
    logic       walk_inc;
    logic       sum_acc;
    logic       ins_latch;
    logic       scan_init;
    logic       scan_inc;
    logic       entry_rd;
    logic       entry_we;
    logic       res_load;
    status_t    res_status;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic out_free;
    logic built;
    logic table_full;
    logic walk_last;
    logic item_last;
    logic ins_over;
    logic scan_end;
    logic key_hit;
  } stat_t;

  // bits -> 30-bit key part (low) and 32-bit rest (high)
  function automatic logic [KMER_W-1:0] scramble(input logic [KMER_W-1:0] k);
    logic [63:0] w;
    logic [31:0] kp;
    logic [31:0] rest;
    w    = {k, 2'b00};
    kp   = (w[63:32] & SCATTER_B) | (w[31:0] & SCATTER_A);
    rest = (w[63:32] & SCATTER_A) | (w[31:0] & SCATTER_B);
    return {rest, kp[31:2]};
  endfunction

  function automatic logic [KMER_W-1:0] rev_complement(input logic [KMER_W-1:0] k);
    logic [KMER_W-1:0] r;
    r = '0;
    for (int i = 0; i < KMER_W / 2; i++) begin
      r[2*(KMER_W/2-1-i) +: 2] = ~k[2*i +: 2];
    end
    return r;
  endfunction

  // swap bits in each base so integer order is A<C<G<T
  function automatic logic [KMER_W-1:0] lex_rank(input logic [KMER_W-1:0] k);
    logic [KMER_W-1:0] r;
    r = '0;
    for (int i = 0; i < KMER_W / 2; i++) begin
      r[2*i +: 2] = {k[2*i], k[2*i+1]};
    end
    return r;
  endfunction

endpackage

// ===== design/canonical_kmer_count_table.sv =====
`timescale 1ns / 1ps
// Wrong phase or a full table gives a result straight from decode (a
// wrong-phase query after the canonical step); the other ops read and write
// the tables first. Throughput: one item at a time, set by the single read
// port of each table and the read-then-compare bucket scan step.
// Reset (rst_n, sync, active low): a clearing pass over all 2^BUCKET_BITS
// buckets zeroes tallies and fill counts; in_tready stays low until it finishes.
module canonical_kmer_count_table
  import ckct_pkg::*;
#(
  parameter int BUCKET_BITS = 12,
  parameter int MAX_ENTRIES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // kmer_bits[61:0], occurrences[93:62], zero pad
  input  logic [1:0]  in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // found_count[31:0], canonical_kmer[93:32],
                                  // was_reversed[94], zero pad
  output logic [1:0]  out_tuser   // status
);

  cmd_t  cmd;
  stat_t st;

  logic [OCC_W-1:0]  found;
  logic [KMER_W-1:0] canon;
  logic              rev;

  // FSM sequences memory accesses; datapath holds tables and counters
  ckct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .st        (st),
    .cmd       (cmd)
  );

  ckct_dp #(
    .BUCKET_BITS (BUCKET_BITS),
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_op      (in_tuser),
    .in_kmer    (in_tdata[61:0]),
    .in_occ     (in_tdata[93:62]),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_status (out_tuser),
    .out_found  (found),
    .out_canon  (canon),
    .out_rev    (rev)
  );

  assign in_tready = cmd.in_ready;
  assign out_tdata = {1'b0, rev, canon, found};

  // one item in flight: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second beat accepted while busy");

  // a result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> (!out_tvalid || out_tready))
    else $error("result register overwritten");

  // only a successful lookup carries a count
  a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_OK) |-> (out_tdata[31:0] == '0))
    else $error("count on failed result");

  // no table write while idle
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !(cmd.entry_we || cmd.fill_we || cmd.start_we))
    else $error("table write while idle");

endmodule

// ===== design/ckct_ctrl.sv =====
`timescale 1ns / 1ps
module ckct_ctrl
  import ckct_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  input  stat_t st,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        cmd.start_we   = 1'b1;
        cmd.start_wsel = WS_ZERO;
        cmd.fill_we    = 1'b1;
        cmd.fill_zero  = 1'b1;
        cmd.walk_inc   = 1'b1;
        if (st.walk_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.in_load  = in_tvalid;
        if (in_tvalid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (st.op)
          OP_COUNT: begin
            if (st.built || st.table_full) begin
              if (st.out_free) begin
                cmd.res_load   = 1'b1;
                cmd.res_status = st.built ? ST_WRONG_PHASE : ST_OVERFLOW;
                state_nxt      = S_IDLE;
              end
            end else begin
              cmd.start_rd  = 1'b1;
              cmd.raddr_sel = RA_ITEM;
              state_nxt     = S_CNT_WR;
            end
          end
          OP_BUILD: begin
            if (st.built) begin
              if (st.out_free) begin
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_WRONG_PHASE;
                state_nxt      = S_IDLE;
              end
            end else begin
              cmd.walk_clr = 1'b1;
              state_nxt    = S_BLD_RD;
            end
          end
          OP_INSERT: begin
            if (!st.built) begin
              if (st.out_free) begin
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_WRONG_PHASE;
                state_nxt      = S_IDLE;
              end
            end else begin
              cmd.start_rd  = 1'b1;
              cmd.fill_rd   = 1'b1;
              cmd.raddr_sel = RA_ITEM;
              state_nxt     = S_INS_RD1;
            end
          end
          default: begin
            cmd.canon_load = 1'b1;
            state_nxt      = S_QRY_RD;
          end
        endcase
      end
      S_CNT_WR: begin
        if (st.out_free) begin
          cmd.start_we   = 1'b1;
          cmd.start_wsel = WS_INC;
          cmd.total_inc  = 1'b1;
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_OK;
          state_nxt      = S_IDLE;
        end
      end
      S_BLD_RD: begin
        cmd.start_rd  = 1'b1;
        cmd.raddr_sel = RA_WALK;
        state_nxt     = S_BLD_WR;
      end
      S_BLD_WR: begin
        if (!st.walk_last) begin
          cmd.start_we   = 1'b1;
          cmd.start_wsel = WS_SUM;
          cmd.sum_acc    = 1'b1;
          cmd.walk_inc   = 1'b1;
          state_nxt      = S_BLD_RD;
        end else if (st.out_free) begin
          cmd.start_we   = 1'b1;
          cmd.start_wsel = WS_SUM;
          cmd.sum_acc    = 1'b1;
          cmd.walk_inc   = 1'b1;
          cmd.phase_set  = 1'b1;
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_OK;
          state_nxt      = S_IDLE;
        end
      end
      S_INS_RD1: begin
        cmd.ins_latch = 1'b1;
        cmd.start_rd  = !st.item_last;
        cmd.raddr_sel = RA_NEXT;
        state_nxt     = S_INS_CHK;
      end
      S_INS_CHK: begin
        if (st.out_free) begin
          cmd.res_load = 1'b1;
          if (st.ins_over) begin
            cmd.res_status = ST_OVERFLOW;
          end else begin
            cmd.res_status = ST_OK;
            cmd.entry_we   = 1'b1;
            cmd.fill_we    = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      S_QRY_RD: begin
        if (!st.built) begin
          if (st.out_free) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_WRONG_PHASE;
            state_nxt      = S_IDLE;
          end
        end else begin
          cmd.start_rd  = 1'b1;
          cmd.fill_rd   = 1'b1;
          cmd.raddr_sel = RA_CANON;
          state_nxt     = S_QRY_LAT;
        end
      end
      S_QRY_LAT: begin
        cmd.ins_latch = 1'b1;
        cmd.scan_init = 1'b1;
        state_nxt     = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        if (st.scan_end) begin
          if (st.out_free) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_NOT_FOUND;
            state_nxt      = S_IDLE;
          end
        end else begin
          cmd.entry_rd = 1'b1;
          state_nxt    = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (st.key_hit) begin
          if (st.out_free) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_OK;
            state_nxt      = S_IDLE;
          end
        end else begin
          cmd.scan_inc = 1'b1;
          state_nxt    = S_SCAN_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/ckct_dp.sv =====
`timescale 1ns / 1ps
module ckct_dp
  import ckct_pkg::*;
#(
  parameter int BUCKET_BITS = 12,
  parameter int MAX_ENTRIES = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output stat_t              st,
  input  logic [1:0]         in_op,
  input  logic [KMER_W-1:0]  in_kmer,
  input  logic [OCC_W-1:0]   in_occ,
  input  logic               out_tready,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [OCC_W-1:0]   out_found,
  output logic [KMER_W-1:0]  out_canon,
  output logic               out_rev
);

  localparam int NB = 1 << BUCKET_BITS;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int KW = KMER_W - BUCKET_BITS;

  logic [CW-1:0]    start_mem [NB];
  logic [CW-1:0]    fill_mem  [NB];
  logic [KW-1:0]    key_mem   [MAX_ENTRIES];
  logic [OCC_W-1:0] cnt_mem   [MAX_ENTRIES];

  logic [CW-1:0]    start_rd_r, fill_rd_r;
  logic [KW-1:0]    key_rd_r;
  logic [OCC_W-1:0] cnt_rd_r;

  op_t               op_r;
  logic [KMER_W-1:0] kmer_r, canon_r;
  logic [OCC_W-1:0]  occ_r;
  logic              rev_r;

  logic [BUCKET_BITS-1:0] walk_r;
  logic [CW-1:0]          sum_r, total_r, st_r, fl_r, scan_r;
  logic                   built_r;

  logic                   out_valid_r;
  status_t                out_status_r;
  logic [OCC_W-1:0]       out_found_r;
  logic [KMER_W-1:0]      out_canon_r;
  logic                   out_rev_r;

  logic [KMER_W-1:0]      s_item, s_canon, rc, canon_nxt;
  logic [BUCKET_BITS-1:0] item_b, canon_b, raddr, swaddr;
  logic [CW-1:0]          start_wdata, end_v, size_v;
  logic [CW:0]            ins_idx, scan_idx;
  logic [IW-1:0]          eaddr;

  assign s_item  = scramble(kmer_r);
  assign s_canon = scramble(canon_r);
  assign item_b  = s_item[BUCKET_BITS-1:0];
  assign canon_b = s_canon[BUCKET_BITS-1:0];
  assign rc      = rev_complement(kmer_r);
  assign canon_nxt = (lex_rank(rc) < lex_rank(kmer_r)) ? rc : kmer_r;

  always_comb begin
    case (cmd.raddr_sel)
      RA_ITEM:  raddr = item_b;
      RA_NEXT:  raddr = item_b + 1'b1;
      RA_CANON: raddr = canon_b;
      default:  raddr = walk_r;
    endcase
    case (cmd.start_wsel)
      WS_INC:  start_wdata = start_rd_r + 1'b1;
      WS_SUM:  start_wdata = sum_r;
      default: start_wdata = '0;
    endcase
  end

  assign swaddr   = (cmd.start_wsel == WS_INC) ? item_b : walk_r;
  assign end_v    = st.item_last ? total_r : start_rd_r;
  assign size_v   = end_v - st_r;
  assign ins_idx  = {1'b0, st_r} + {1'b0, fl_r};
  assign scan_idx = {1'b0, st_r} + {1'b0, scan_r};
  assign eaddr    = cmd.entry_we ? ins_idx[IW-1:0] : scan_idx[IW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.start_we) begin
      start_mem[swaddr] <= start_wdata;
    end
    if (cmd.start_rd) begin
      start_rd_r <= start_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill_we) begin
      if (cmd.fill_zero) begin
        fill_mem[walk_r] <= '0;
      end else begin
        fill_mem[item_b] <= fl_r + 1'b1;
      end
    end
    if (cmd.fill_rd) begin
      fill_rd_r <= fill_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.entry_we) begin
      key_mem[eaddr] <= s_item[KMER_W-1:BUCKET_BITS];
      cnt_mem[eaddr] <= occ_r;
    end
    if (cmd.entry_rd) begin
      key_rd_r <= key_mem[eaddr];
      cnt_rd_r <= cnt_mem[eaddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      op_r   <= op_t'(in_op);
      kmer_r <= in_kmer;
      occ_r  <= in_occ;
    end
    if (cmd.canon_load) begin
      canon_r <= canon_nxt;
      rev_r   <= (canon_nxt != kmer_r);
    end
    if (cmd.ins_latch) begin
      st_r <= start_rd_r;
      fl_r <= fill_rd_r;
    end
    if (cmd.scan_init) begin
      scan_r <= '0;
    end else if (cmd.scan_inc) begin
      scan_r <= scan_r + 1'b1;
    end
    if (cmd.walk_clr) begin
      sum_r <= '0;
    end else if (cmd.sum_acc) begin
      sum_r <= sum_r + start_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_r      <= '0;
      total_r     <= '0;
      built_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.walk_clr) begin
        walk_r <= '0;
      end else if (cmd.walk_inc) begin
        walk_r <= walk_r + 1'b1;
      end
      if (cmd.total_inc) begin
        total_r <= total_r + 1'b1;
      end
      if (cmd.phase_set) begin
        built_r <= 1'b1;
      end
      if (cmd.res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_status_r <= cmd.res_status;
      out_found_r  <= (op_r == OP_QUERY && cmd.res_status == ST_OK) ? cnt_rd_r : '0;
      out_canon_r  <= (op_r == OP_QUERY) ? canon_r : '0;
      out_rev_r    <= (op_r == OP_QUERY) ? rev_r : 1'b0;
    end
  end

  always_comb begin
    st.op         = op_r;
    st.out_free   = !out_valid_r || out_tready;
    st.built      = built_r;
    st.table_full = (total_r >= CW'(MAX_ENTRIES));
    st.walk_last  = &walk_r;
    st.item_last  = &item_b;
    st.ins_over   = (fl_r >= size_v) || (ins_idx >= (CW+1)'(MAX_ENTRIES));
    st.scan_end   = (scan_r >= fl_r) || (scan_idx >= (CW+1)'(MAX_ENTRIES));
    st.key_hit    = (key_rd_r == s_canon[KMER_W-1:BUCKET_BITS]);
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_found  = out_found_r;
  assign out_canon  = out_canon_r;
  assign out_rev    = out_rev_r;

endmodule

// ===== verif/canonical_kmer_count_table_checker.sv =====
`timescale 1ns / 1ps
module canonical_kmer_count_table_checker
  import ckct_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [95:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [95:0] out_tdata,
  input  logic [1:0]  out_tuser,
  output int          fail_count,
  output int          pending
);

  localparam int NB   = 4096;
  localparam int MAXE = 4096;

  typedef struct {
    status_t     st;
    logic [31:0] found;
    logic [61:0] canon;
    logic        rev;
  } answer_t;

  answer_t     answers[$];
  int unsigned tally_or_start[NB];
  int unsigned fill[NB];
  logic [49:0] slot_rem[MAXE];
  logic [31:0] slot_occ[MAXE];
  int unsigned total;
  logic        built;

  // scattered split: kmer<<2 halves masked into key part (low 30) and rest
  function automatic logic [61:0] scatter(input logic [61:0] k);
    logic [63:0] w;
    logic [31:0] kp, rs;
    w  = {k, 2'b00};
    kp = (w[63:32] & SCATTER_B) | (w[31:0] & SCATTER_A);
    rs = (w[63:32] & SCATTER_A) | (w[31:0] & SCATTER_B);
    return {rs, kp[31:2]};
  endfunction

  function automatic logic [61:0] revcomp(input logic [61:0] k);
    logic [61:0] r;
    for (int i = 0; i < 31; i++) r[60-2*i +: 2] = k[2*i +: 2] ^ 2'b11;
    return r;
  endfunction

  // base order A<C<G<T, first base most significant
  function automatic bit lex_less(input logic [61:0] a, input logic [61:0] b);
    logic [1:0] ra, rb;
    for (int i = 30; i >= 0; i--) begin
      ra = {a[2*i], a[2*i+1]};
      rb = {b[2*i], b[2*i+1]};
      if (ra != rb) return ra < rb;
    end
    return 0;
  endfunction

  function automatic answer_t predict(input op_t op, input logic [61:0] k,
                                      input logic [31:0] occ);
    answer_t     a;
    logic [61:0] s, rc;
    int unsigned b, sum, t, lim, idx;
    a = '{ST_OK, '0, '0, 1'b0};
    s = scatter(k);
    b = s[11:0];
    case (op)
      OP_COUNT: begin
        if (built) a.st = ST_WRONG_PHASE;
        else if (total >= MAXE) a.st = ST_OVERFLOW;
        else begin
          tally_or_start[b]++;
          total++;
        end
      end
      OP_BUILD: begin
        if (built) a.st = ST_WRONG_PHASE;
        else begin
          sum = 0;
          for (int i = 0; i < NB; i++) begin
            t = tally_or_start[i];
            tally_or_start[i] = sum;
            sum += t;
          end
          built = 1;
        end
      end
      OP_INSERT: begin
        if (!built) a.st = ST_WRONG_PHASE;
        else begin
          lim = (b + 1 < NB) ? tally_or_start[b+1] : total;
          idx = tally_or_start[b] + fill[b];
          if (fill[b] >= lim - tally_or_start[b] || idx >= MAXE) a.st = ST_OVERFLOW;
          else begin
            slot_rem[idx] = s[61:12];
            slot_occ[idx] = occ;
            fill[b]++;
          end
        end
      end
      default: begin
        rc = revcomp(k);
        if (lex_less(rc, k)) begin
          a.canon = rc;
          a.rev   = 1'b1;
        end else a.canon = k;
        if (!built) a.st = ST_WRONG_PHASE;
        else begin
          s    = scatter(a.canon);
          b    = s[11:0];
          a.st = ST_NOT_FOUND;
          for (int i = 0; i < fill[b]; i++) begin
            idx = tally_or_start[b] + i;
            if (idx >= MAXE) break;
            if (slot_rem[idx] == s[61:12]) begin
              a.found = slot_occ[idx];
              a.st    = ST_OK;
              break;
            end
          end
        end
      end
    endcase
    return a;
  endfunction

  initial begin
    fail_count = 0;
    total      = 0;
    built      = 0;
    for (int i = 0; i < NB; i++) begin
      tally_or_start[i] = 0;
      fill[i]           = 0;
    end
  end

  assign pending = answers.size();

  always @(posedge clk) begin
    answer_t e;
    if (rst_n && in_tvalid && in_tready)
      answers.push_back(predict(op_t'(in_tuser), in_tdata[61:0], in_tdata[93:62]));
    if (rst_n && out_tvalid && out_tready) begin
      if (answers.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result beat: status %0d", out_tuser);
      end else begin
        e = answers.pop_front();
        if (out_tuser != e.st || out_tdata[31:0] != e.found ||
            out_tdata[93:32] != e.canon || out_tdata[94] != e.rev) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: exp st %0d cnt %h canon %h rev %b / got st %0d cnt %h canon %h rev %b",
                     e.st, e.found, e.canon, e.rev, out_tuser, out_tdata[31:0],
                     out_tdata[93:32], out_tdata[94]);
        end
      end
    end
  end

endmodule

// ===== verif/canonical_kmer_count_table_tb.sv =====
`timescale 1ns / 1ps
module canonical_kmer_count_table_tb
  import ckct_pkg::*;
();

  localparam int LIMIT = 3000000;  // cycles

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;   // kmer_bits[61:0], occurrences[93:62], pad
  logic [1:0]  in_tuser = '0;   // operation
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [95:0] out_tdata;       // found_count, canonical_kmer, was_reversed, pad
  logic [1:0]  out_tuser;       // status
  int          fail_count, pending;
  int          cycles = 0;

  // sink-side controls
  logic        long_hold_req = 0;
  logic        long_done = 0;
  int          hold_cnt = 0;
  logic        rx_burst = 0;
  int          rx_beats = 0;
  // source-side controls
  logic        tx_burst = 0;
  int          tx_items = 0;

  logic [61:0] counted[$];   // k-mers tallied, duplicates kept; all canonical but the all-ones key
  logic [61:0] stored[$];    // k-mers inserted so far

  canonical_kmer_count_table dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  canonical_kmer_count_table_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("canonical_kmer_count_table_tb failed");
      $finish;
    end
  end

  // result sink: a random stall after each beat, burst stretches with none,
  // and one long hold-off so the block backs up into its input
  always @(posedge clk) begin
    int g;
    if (!rst_n) begin
      out_tready <= 0;
    end else if (long_hold_req && !long_done) begin
      long_done  <= 1;
      out_tready <= 0;
      hold_cnt   <= 600;
    end else if (hold_cnt != 0) begin
      out_tready <= 0;
      hold_cnt   <= hold_cnt - 1;
    end else if (out_tready && out_tvalid) begin
      rx_beats <= rx_beats + 1;
      if (rx_beats % 64 == 63) rx_burst <= ($urandom_range(0, 2) == 0);
      g = rx_burst ? 0 : $urandom_range(0, 16);
      if (g == 0) out_tready <= 1;
      else begin
        out_tready <= 0;
        hold_cnt   <= g;
      end
    end else if (!out_tready) begin
      out_tready <= 1;
    end
  end

  function automatic logic [61:0] rc_of(input logic [61:0] k);
    logic [61:0] r;
    for (int i = 0; i < 31; i++) r[60-2*i +: 2] = ~k[2*i +: 2];
    return r;
  endfunction

  function automatic logic [61:0] rand_kmer();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[61:0];
  endfunction

  // one input beat; valid stays high across back-to-back items
  task automatic send(input op_t op, input logic [61:0] k, input logic [31:0] occ);
    int g;
    tx_items++;
    if (tx_items % 50 == 0) tx_burst = ($urandom_range(0, 2) == 0);
    g = tx_burst ? 0 : $urandom_range(0, 16);
    if (g != 0) begin
      in_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, occ, k};
    do @(posedge clk); while (!in_tready);
  endtask

  // Canonical k-mers: first and last base A, so the reverse complement starts
  // with T. Bits 59:44 and 29:12 only reach the stored remainder, so varying
  // them keeps the bucket and builds multi-entry buckets.
  task automatic make_groups(input int want);
    logic [61:0] base, mate;
    int n, rep;
    while (counted.size() < want) begin
      base = rand_kmer();
      base[61:60] = 2'b00;
      base[1:0]   = 2'b00;
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
        mate = base;
        if (i != 0) begin
          mate[59:44] = 16'($urandom);
          mate[29:12] = 18'($urandom);
        end
        rep = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 3) : 1;
        repeat (rep) counted.push_back(mate);
      end
    end
  endtask

  task automatic query_some();
    logic [61:0] k;
    if (stored.size() != 0 && $urandom_range(0, 3) != 0) begin
      k = stored[$urandom_range(0, stored.size() - 1)];
      if ($urandom_range(0, 1)) k = rc_of(k);  // reverse-complement lookup
    end else k = rand_kmer();                 // mostly a miss
    send(OP_QUERY, k, $urandom);
  endtask

  initial begin
    int idx;
    repeat (12) @(posedge clk);
    rst_n <= 1;

    // wrong phase before build; extremes of the k-mer
    send(OP_INSERT, '0, '0);
    send(OP_INSERT, '1, '1);
    send(OP_QUERY, '0, '0);
    send(OP_QUERY, '1, '1);
    send(OP_QUERY, rand_kmer(), $urandom);

    // tally phase
    make_groups(400);
    counted.push_back('0);
    counted.push_back('1);
    counted.shuffle();
    foreach (counted[i]) send(OP_COUNT, counted[i], $urandom);
    // a repeated tally and a lone random key leave spare slots
    send(OP_COUNT, counted[0], '0);
    send(OP_COUNT, rand_kmer(), '1);

    // prefix sum; a second build and a late count are in the wrong phase
    send(OP_BUILD, rand_kmer(), $urandom);
    send(OP_BUILD, '0, '0);
    send(OP_COUNT, counted[1], $urandom);

    // insert phase with interleaved lookups
    send(OP_INSERT, counted[0], '0);
    stored.push_back(counted[0]);
    send(OP_INSERT, counted[1], '1);
    stored.push_back(counted[1]);
    send(OP_QUERY, counted[0], $urandom);
    send(OP_QUERY, rc_of(counted[1]), $urandom);
    for (int i = 2; i < counted.size(); i++) begin
      if (i == 300) long_hold_req <= 1;
      send(OP_INSERT, counted[i], $urandom);
      stored.push_back(counted[i]);
      if ($urandom_range(0, 9) == 0) send(OP_INSERT, rand_kmer(), $urandom);
      if ($urandom_range(0, 2) == 0) query_some();
    end

    // buckets already full
    repeat (20) begin
      idx = $urandom_range(0, counted.size() - 1);
      send(OP_INSERT, counted[idx], $urandom);
    end
    repeat (250) query_some();

    @(posedge clk);
    in_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("canonical_kmer_count_table_tb passed");
    else $display("canonical_kmer_count_table_tb failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/ckct_pkg.sv
design/ckct_ctrl.sv
design/ckct_dp.sv
design/canonical_kmer_count_table.sv
verif/canonical_kmer_count_table_checker.sv
verif/canonical_kmer_count_table_tb.sv
